FILE: hdl/cla_pkg.sv
// shared types, constants and register codes of the coherent line averager
package cla_pkg;

	// defaults for the top-level parameters
	localparam int SAMPLE_W_DEF    = 16;
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int MAX_LINES_DEF   = 64;

	// register field widths
	localparam int LINES_CFG_W = 7;
	localparam int SAMP_CFG_W  = 13;
	localparam int CHAN_CFG_W  = 8;
	localparam int GAIN_W      = 16;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// channel counter
	localparam int CHAN_LIMIT = 128;
	localparam int CHAN_W     = 7;

	// register reset values
	localparam logic [LINES_CFG_W-1:0] LINES_RESET = LINES_CFG_W'(1);
	localparam logic [SAMP_CFG_W-1:0]  SAMP_RESET  = SAMP_CFG_W'(1024);
	localparam logic [CHAN_CFG_W-1:0]  CHAN_RESET  = CHAN_CFG_W'(1);
	localparam logic [GAIN_W-1:0]      GAIN_RESET  = GAIN_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINES    = 4'd0,
		REG_SAMPLES  = 4'd1,
		REG_CHANNELS = 4'd2,
		REG_GAIN     = 4'd3
	} cla_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} cla_state_t;

	typedef struct packed {
		logic capture;
		logic accumulate;
		logic multiply;
		logic load_div;
		logic div_step;
		logic out_load;
	} cla_cmd_t;

	typedef struct packed {
		logic last_line;
		logic div_done;
		logic out_free;
	} cla_sts_t;

endpackage

FILE: hdl/cla_sample_if.sv
// input sample channel
interface cla_sample_if
	import cla_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: hdl/cla_result_if.sv
// averaged result channel
interface cla_result_if
	import cla_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] avg_sample;
	logic                           line_end;
	logic                           frame_end;

	modport source (output valid, output avg_sample, output line_end, output frame_end,
		input ready);
	modport sink   (input valid, input avg_sample, input line_end, input frame_end,
		output ready);
endinterface

FILE: hdl/cla_cfg_if.sv
// configuration write channel
interface cla_cfg_if
	import cla_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/cla_cfg_regs.sv
// configuration registers with range clamping
module cla_cfg_regs
	import cla_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int MAX_LINES   = MAX_LINES_DEF,
	localparam int NS_W = $clog2(MAX_SAMPLES + 1),
	localparam int NL_W = $clog2(MAX_LINES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	cla_cfg_if.sink           cfg,
	output logic [NL_W-1:0]   n_lines,
	output logic [NS_W-1:0]   n_samp,
	output logic [CHAN_CFG_W-1:0] n_chan,
	output logic [GAIN_W-1:0] gain
);

	logic [LINES_CFG_W-1:0] lines_q;
	logic [SAMP_CFG_W-1:0]  samp_q;
	logic [CHAN_CFG_W-1:0]  chan_q;
	logic [GAIN_W-1:0]      gain_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= LINES_RESET;
			samp_q  <= SAMP_RESET;
			chan_q  <= CHAN_RESET;
			gain_q  <= GAIN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LINES:    lines_q <= cfg.data[LINES_CFG_W-1:0];
				REG_SAMPLES:  samp_q  <= cfg.data[SAMP_CFG_W-1:0];
				REG_CHANNELS: chan_q  <= cfg.data[CHAN_CFG_W-1:0];
				REG_GAIN:     gain_q  <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, large values stop at the store and channel counter limits
	always_comb begin
		if (lines_q == '0)
			n_lines = NL_W'(1);
		else if (32'(lines_q) > MAX_LINES)
			n_lines = NL_W'(MAX_LINES);
		else
			n_lines = NL_W'(lines_q);

		if (samp_q == '0)
			n_samp = NS_W'(1);
		else if (32'(samp_q) > MAX_SAMPLES)
			n_samp = NS_W'(MAX_SAMPLES);
		else
			n_samp = NS_W'(samp_q);

		if (chan_q == '0)
			n_chan = CHAN_CFG_W'(1);
		else if (32'(chan_q) > CHAN_LIMIT)
			n_chan = CHAN_CFG_W'(CHAN_LIMIT);
		else
			n_chan = chan_q;
	end

	assign gain = gain_q;

endmodule

FILE: hdl/cla_ctrl.sv
// sequencer for capture, accumulate, scale, divide and output steps
module cla_ctrl
	import cla_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cla_sts_t sts,
	output cla_cmd_t cmd
);

	cla_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_next = ST_ACC;
			ST_ACC:  state_next = sts.last_line ? ST_MUL : ST_IDLE;
			ST_MUL:  state_next = ST_LOAD;
			ST_LOAD: state_next = ST_DIV;
			ST_DIV:  if (sts.div_done) state_next = ST_OUT;
			ST_OUT:  if (sts.out_free) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ACC:  cmd.accumulate = 1'b1;
			ST_MUL:  cmd.multiply   = 1'b1;
			ST_LOAD: cmd.load_div   = 1'b1;
			ST_DIV:  cmd.div_step   = !sts.div_done;
			ST_OUT:  cmd.out_load   = sts.out_free;
			default: ;
		endcase
	end

	a_capture_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_ACC)
		else $error("capture did not move to accumulate");

	a_out_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE && !cmd.out_load)
		else $error("result loaded twice");

endmodule

FILE: hdl/cla_datapath.sv
// counters, line store, gain multiply, bit-serial divide and output register
module cla_datapath
	import cla_pkg::*;
#(
	parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
	parameter int MAX_LINES    = MAX_LINES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
	localparam int NS_W = $clog2(MAX_SAMPLES + 1),
	localparam int NL_W = $clog2(MAX_LINES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cla_cmd_t                       cmd,
	output cla_sts_t                       sts,
	input  logic [NL_W-1:0]                n_lines,
	input  logic [NS_W-1:0]                n_samp,
	input  logic [CHAN_CFG_W-1:0]          n_chan,
	input  logic [GAIN_W-1:0]              gain,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	cla_result_if.source                   results
);

	localparam int ADDR_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int LP_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int ACC_W   = SAMPLE_WIDTH + $clog2(MAX_LINES);
	localparam int PROD_W  = ACC_W + GAIN_W + 1;
	// |product| stays below 2**(PROD_W-2); after dropping the 8 fraction bits
	localparam int DIV_W   = PROD_W - 10;
	localparam int DC_W    = $clog2(DIV_W + 1);
	localparam logic [DIV_W-1:0] POS_MAX =
		DIV_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic [DIV_W-1:0] NEG_MAG = POS_MAX + DIV_W'(1);
	localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// position counters
	logic [ADDR_W-1:0] sample_pos_q;
	logic [LP_W-1:0]   line_pos_q;
	logic [CHAN_W-1:0] channel_pos_q;
	logic              last_line, last_samp, last_chan;

	// captured word and its flags
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic [ADDR_W-1:0]              addr_q;
	logic                           first_q, last_line_q, line_end_q, frame_end_q;

	// line store
	logic signed [ACC_W-1:0] store [MAX_SAMPLES];
	logic signed [ACC_W-1:0] rd_q;
	logic signed [ACC_W-1:0] acc_next, acc_q;

	// scale and divide
	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]        prod_abs;
	logic                     neg_q;
	logic [DIV_W-1:0]         quo_q;
	logic [NL_W:0]            rem_q, trial;
	logic                     fits;
	logic [DC_W-1:0]          div_cnt_q;

	// output register
	logic                    out_valid_q;
	logic                    out_free;
	logic [SAMPLE_WIDTH-1:0] sat_val;

	assign last_line = (32'(line_pos_q) + 32'd1) >= 32'(n_lines);
	assign last_samp = (32'(sample_pos_q) + 32'd1) >= 32'(n_samp);
	assign last_chan = (32'(channel_pos_q) + 32'd1) >= 32'(n_chan);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_pos_q  <= '0;
			line_pos_q    <= '0;
			channel_pos_q <= '0;
		end else if (cmd.capture) begin
			if (last_samp) begin
				sample_pos_q <= '0;
				if (last_line) begin
					line_pos_q    <= '0;
					channel_pos_q <= last_chan ? '0 : channel_pos_q + CHAN_W'(1);
				end else begin
					line_pos_q <= line_pos_q + LP_W'(1);
				end
			end else begin
				sample_pos_q <= sample_pos_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q    <= sample_in;
			addr_q      <= sample_pos_q;
			first_q     <= (line_pos_q == '0);
			last_line_q <= last_line;
			line_end_q  <= last_samp;
			frame_end_q <= last_samp && last_chan;
		end
	end

	// first repeated line overwrites, later lines add
	assign acc_next = first_q ? ACC_W'(sample_q) : rd_q + ACC_W'(sample_q);

	always_ff @(posedge clk) begin
		if (cmd.accumulate)
			store[addr_q] <= acc_next;
		if (cmd.capture)
			rd_q <= store[sample_pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accumulate)
			acc_q <= acc_next;
		if (cmd.multiply)
			prod_q <= acc_q * $signed({1'b0, gain});
	end

	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

	// restoring divide by the line count, one quotient bit a cycle
	assign trial = {rem_q[NL_W-1:0], quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, n_lines};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load_div) begin
			div_cnt_q <= DC_W'(DIV_W);
		end else if (cmd.div_step && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			neg_q <= prod_q[PROD_W-1];
			quo_q <= prod_abs[PROD_W-3:8];
			rem_q <= '0;
		end else if (cmd.div_step && div_cnt_q != '0) begin
			rem_q <= fits ? trial - {1'b0, n_lines} : trial;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q)
			sat_val = (quo_q > NEG_MAG) ? SAT_MIN : SAMPLE_WIDTH'(DIV_W'(0) - quo_q);
		else
			sat_val = (quo_q > POS_MAX) ? SAT_MAX : SAMPLE_WIDTH'(quo_q);
	end

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			results.avg_sample <= $signed(sat_val);
			results.line_end   <= line_end_q;
			results.frame_end  <= frame_end_q;
		end
	end

	assign results.valid = out_valid_q;

	assign sts.last_line = last_line_q;
	assign sts.div_done  = (div_cnt_q == '0);
	assign sts.out_free  = out_free;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || results.ready))
		else $error("pending result overwritten");

	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_div |=> (div_cnt_q == DC_W'(DIV_W) && rem_q == '0))
		else $error("divider not initialized");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && div_cnt_q != '0 |=> rem_q < {1'b0, n_lines})
		else $error("divider remainder out of range");

endmodule

FILE: hdl/coherent_line_averager_unit.sv
// top level of the coherent line averager with gain
//
//  channel   dir   handshake        payload
//  samples   in    valid / ready    sample_in
//  results   out   valid / ready    avg_sample, line_end, frame_end
//  cfg       in    valid / ready    index, data (ready always high)
//
// a word on a line that is not the last repeated line is accepted with a store
// read, then added and written back; a word on the last line then passes the
// gain multiply, the divider load, the bit-serial divide by the line count and
// the output load. reset clears the counters, state, configuration registers
// and output valid flag only; the line store is filled by the first repeated
// line, so no clearing pass runs. a result held by a stalled sink does not block
// the next accept, but the next result load waits for it and stalls accepts.
module coherent_line_averager_unit
	import cla_pkg::*;
#(
	parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
	parameter int MAX_LINES    = MAX_LINES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cla_sample_if.sink   samples,
	cla_result_if.source results,
	cla_cfg_if.sink      cfg
);

	localparam int NS_W = $clog2(MAX_SAMPLES + 1);
	localparam int NL_W = $clog2(MAX_LINES + 1);

	logic [NL_W-1:0]       n_lines;
	logic [NS_W-1:0]       n_samp;
	logic [CHAN_CFG_W-1:0] n_chan;
	logic [GAIN_W-1:0]     gain;
	cla_cmd_t              cmd;
	cla_sts_t              sts;

	cla_cfg_regs #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_LINES  (MAX_LINES)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.n_lines(n_lines),
		.n_samp (n_samp),
		.n_chan (n_chan),
		.gain   (gain)
	);

	cla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cla_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_LINES   (MAX_LINES),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.n_lines  (n_lines),
		.n_samp   (n_samp),
		.n_chan   (n_chan),
		.gain     (gain),
		.sample_in(samples.sample_in),
		.results  (results)
	);

endmodule
